@@ hw/rtl/ddp_pkg.sv @@
// Shared types and constants for the DDP pixel packet receiver.
// No dependencies.
package ddp_pkg;

  localparam int unsigned HDR_LEN = 11;
  localparam logic [15:0] TYPE_RGB = 16'h0001;
  localparam int unsigned RGB_BYTES = 3;

  // Header byte positions of the captured big-endian fields.
  localparam logic [3:0] POS_TYPE_HI  = 4'd3;
  localparam logic [3:0] POS_TYPE_LO  = 4'd4;
  localparam logic [3:0] POS_START_HI = 4'd7;
  localparam logic [3:0] POS_START_LO = 4'd8;
  localparam logic [3:0] POS_LEN_HI   = 4'd9;
  localparam logic [3:0] POS_LEN_LO   = 4'd10;
  localparam logic [3:0] POS_PAYLOAD  = 4'(HDR_LEN);

  localparam int unsigned ADDR_W = 12;
  localparam int unsigned LEN_W  = 16;

  // Header parser to write stage.
  typedef struct packed {
    logic              in_payload;  // header done, byte is payload
    logic              at_len;      // byte is the last header byte
    logic              ok;          // packet passes the checks (valid with at_len)
    logic [ADDR_W-1:0] addr;        // first write address
    logic [LEN_W-1:0]  len;         // bytes to write after truncation
  } hdr_info_t;

endpackage

@@ hw/rtl/ddp_hdr.sv @@
// Header byte counter, field capture and packet acceptance check.
// Depends on ddp_pkg.
module ddp_hdr
  import ddp_pkg::*;
#(
  parameter int unsigned MAX_BUFFER_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  pkt_byte,
  input  logic        last_byte,
  input  logic [12:0] buffer_bytes,
  output hdr_info_t   info
);

  localparam int unsigned EFF_W = $clog2(MAX_BUFFER_BYTES + 1);
  localparam int unsigned CMP_W = (EFF_W > 13) ? EFF_W : 13;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_BUFFER_BYTES);

  logic [3:0]  pos;
  logic        type_ok;
  logic [7:0]  start_hi;
  logic [17:0] dst;
  logic [7:0]  len_hi;

  logic [15:0]      len_full;
  logic [15:0]      start_full;
  logic [EFF_W-1:0] eff;
  logic [18:0]      room;
  logic             room_pos;
  logic [LEN_W-1:0] len_cut;

  // x mod 3: base-4 digits sum to the same residue, folded twice.
  function automatic logic [1:0] mod3_16(input logic [15:0] x);
    logic [4:0] s;
    logic [2:0] t;
    s = 5'd0;
    for (int i = 0; i < 8; i++) begin
      s = s + 5'(x[2*i +: 2]);
    end
    t = 3'(s[4]) + 3'(s[3:2]) + 3'(s[1:0]);
    if (t >= 3'd6) begin
      mod3_16 = 2'(t - 3'd6);
    end else if (t >= 3'd3) begin
      mod3_16 = 2'(t - 3'd3);
    end else begin
      mod3_16 = t[1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 4'd0;
    end else if (step) begin
      if (last_byte) begin
        pos <= 4'd0;
      end else if (pos != POS_PAYLOAD) begin
        pos <= pos + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      case (pos)
        POS_TYPE_HI:  type_ok <= (pkt_byte == TYPE_RGB[15:8]);
        POS_TYPE_LO:  type_ok <= type_ok && (pkt_byte == TYPE_RGB[7:0]);
        POS_START_HI: start_hi <= pkt_byte;
        POS_START_LO: dst <= {1'b0, start_full, 1'b0} + {2'b00, start_full};
        POS_LEN_HI:   len_hi <= pkt_byte;
        default: ;
      endcase
    end
  end

  assign start_full = {start_hi, pkt_byte};
  assign len_full   = {len_hi, pkt_byte};

  always_comb begin
    if (CMP_W'(buffer_bytes) > MAX_CMP) begin
      eff = EFF_W'(MAX_CMP);
    end else begin
      eff = EFF_W'(buffer_bytes);
    end
    room     = 19'(eff) - {1'b0, dst};
    room_pos = (19'(eff) > {1'b0, dst});
    if (19'(len_full) > room) begin
      len_cut = room[LEN_W-1:0];
    end else begin
      len_cut = len_full;
    end
  end

  always_comb begin
    info.in_payload = (pos == POS_PAYLOAD);
    info.at_len     = (pos == POS_LEN_LO);
    info.ok         = type_ok && (len_full != 16'd0) && (mod3_16(len_full) == 2'd0)
                      && room_pos;
    info.addr       = dst[ADDR_W-1:0];
    info.len        = len_cut;
  end

endmodule

@@ hw/rtl/ddp_wr.sv @@
// Payload write counters and the result register with its output handshake.
// Depends on ddp_pkg.
module ddp_wr
  import ddp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  pkt_byte,
  input  logic        last_byte,
  input  hdr_info_t   info,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_data,
  output logic        out_last
);

  logic              accepted;
  logic [ADDR_W-1:0] next_addr;
  logic [LEN_W-1:0]  left;
  logic              wr;
  logic              fd;

  assign wr = info.in_payload && accepted && (left != '0);
  assign fd = last_byte && ((info.at_len && info.ok) || (info.in_payload && accepted));

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted  <= 1'b0;
      left      <= '0;
      next_addr <= '0;
    end else if (step) begin
      if (info.at_len) begin
        accepted  <= info.ok;
        next_addr <= info.addr;
        left      <= info.ok ? info.len : '0;
      end else if (wr) begin
        next_addr <= next_addr + ADDR_W'(1);
        left      <= left - LEN_W'(1);
      end
      if (last_byte) begin
        accepted <= 1'b0;
        left     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= {3'b000, (wr ? pkt_byte : 8'd0), (wr ? next_addr : {ADDR_W{1'b0}}), wr};
      out_last <= fd;
    end
  end

endmodule

@@ hw/rtl/ddp_pixel_packet_receiver.sv @@
// DDP pixel packet receiver top level; built from ddp_pkg, ddp_hdr and ddp_wr.
// One UDP payload byte in, one LED-buffer write result out per transaction.
// Each input transaction's result is registered in the output register.
// Throughput: 1 byte per cycle; the single result register stalls input only
// while it holds a result that the sink has not taken.
// Reset (rst, synchronous): header at byte 0, no packet, output empty, buffer_bytes 4096.
module ddp_pixel_packet_receiver
  import ddp_pkg::*;
#(
  parameter int unsigned MAX_BUFFER_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // Config: buffer_bytes, always ready
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data,       // [12:0] buffer_bytes
  // Input bytes
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,        // [7:0] pkt_byte
  input  logic        s_tlast,        // last_byte
  // Results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,        // [0] write_enable, [12:1] write_address,
                                      // [20:13] write_data, [23:21] zero
  output logic        m_tlast         // frame_done
);

  logic [12:0] buffer_bytes;
  logic        step;
  hdr_info_t   info;

  // Register writes are accepted at once; the header stage samples at length byte.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_bytes <= 13'd4096;
    end else if (cfg_valid) begin
      buffer_bytes <= cfg_data;
    end
  end

  // Take a byte whenever the result register is free or being drained.
  assign s_tready = !m_tvalid || m_tready;
  assign step     = s_tvalid && s_tready;

  // Header counter, capture of type/start/length, accept and truncate.
  ddp_hdr #(
    .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
  ) u_hdr (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .pkt_byte    (s_tdata),
    .last_byte   (s_tlast),
    .buffer_bytes(buffer_bytes),
    .info        (info)
  );

  // Write address/count tracking and the result register.
  ddp_wr u_wr (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .pkt_byte (s_tdata),
    .last_byte(s_tlast),
    .info     (info),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (m_tdata),
    .out_last (m_tlast)
  );

endmodule
